>>> rtl/core/mdws_pkg.sv
// ----------------------------------------------------------------------------
// mdws_pkg
// Shared types and constants for the moving-window deviation motion detector.
// ----------------------------------------------------------------------------
package mdws_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LIMIT_W  = 15;
	localparam int AXES     = 3;
	localparam int ENTRY_W  = AXES * SAMPLE_W;

	// configuration register indexes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_LIMIT_X = 2'd0,
		REG_LIMIT_Y = 2'd1,
		REG_LIMIT_Z = 2'd2
	} reg_idx_t;

	typedef logic [AXES-1:0][LIMIT_W-1:0] limits_t;
	typedef logic [AXES-1:0][SAMPLE_W-1:0] sample_t;

	// datapath step commands from the sequencer
	typedef struct packed {
		logic load;    // capture sample, read the ring entry to be replaced
		logic square;  // square new and old samples, update sums, write ring
		logic accum;   // update square sums, take sum magnitudes
		logic mul1;    // n*Q, S*S, limit*n
		logic mul2;    // n*Q - S*S, (limit*n)^2
		logic cmp;     // compare and load the result register
	} cmd_t;

endpackage

>>> rtl/core/mdws_ram.sv
// ----------------------------------------------------------------------------
// mdws_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mdws_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/mdws_ctrl.sv
// ----------------------------------------------------------------------------
// mdws_ctrl
// Sequencer: steps one sample through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module mdws_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output mdws_pkg::cmd_t cmd
);

	import mdws_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_MUL1,
		ST_MUL2,
		ST_CMP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// result register can take a new value if empty or emptied at this edge
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.square = (state_q == ST_SQUARE);
		cmd.accum  = (state_q == ST_ACCUM);
		cmd.mul1   = (state_q == ST_MUL1);
		cmd.mul2   = (state_q == ST_MUL2);
		cmd.cmp    = (state_q == ST_CMP) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: state_q <= ST_ACCUM;
				ST_ACCUM:  state_q <= ST_MUL1;
				ST_MUL1:   state_q <= ST_MUL2;
				ST_MUL2:   state_q <= ST_CMP;
				ST_CMP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/mdws_datapath.sv
// ----------------------------------------------------------------------------
// mdws_datapath
// Sample ring, running sums per axis and the deviation test arithmetic.
// ----------------------------------------------------------------------------
module mdws_datapath #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mdws_pkg::cmd_t   cmd,
	input  mdws_pkg::sample_t smp_in,
	input  mdws_pkg::limits_t limits,
	output logic             moving
);

	import mdws_pkg::*;

	localparam int AW   = $clog2(WINDOW_DEPTH);
	localparam int CW   = $clog2(WINDOW_DEPTH + 1);
	localparam int SW   = SAMPLE_W + AW;          // signed running sum
	localparam int PW   = 2 * SAMPLE_W - 1;       // one square
	localparam int QW   = PW + AW;                // running sum of squares
	localparam int NQW  = CW + QW;
	localparam int DW   = (NQW > 2 * SW) ? NQW : 2 * SW;
	localparam int BNW  = LIMIT_W + CW;
	localparam int BW   = 2 * BNW;
	localparam int CMPW = (DW > BW) ? DW : BW;

	logic [AW-1:0]        slot_q;
	logic [CW-1:0]        fill_q;
	logic                 full;
	logic [ENTRY_W-1:0]   old_raw;

	logic signed [SW-1:0] sum_q  [AXES];
	logic [QW-1:0]        sq_q   [AXES];

	logic signed [SAMPLE_W-1:0] smp_q [AXES];
	logic signed [SAMPLE_W-1:0] old_v [AXES];
	logic [PW-1:0]        sqn_s2 [AXES];
	logic [PW-1:0]        sqo_s2 [AXES];
	logic [SW-1:0]        mag_s3 [AXES];
	logic [NQW-1:0]       nq_s4  [AXES];
	logic [2*SW-1:0]      s2_s4  [AXES];
	logic [BNW-1:0]       bnd_s4 [AXES];
	logic [DW-1:0]        diff_s5 [AXES];
	logic [BW-1:0]        b2_s5  [AXES];
	logic                 moving_q;

	logic signed [2*SAMPLE_W-1:0] pn [AXES];
	logic signed [2*SAMPLE_W-1:0] po [AXES];
	logic [AXES-1:0]      over;

	assign full = (fill_q == CW'(WINDOW_DEPTH));

	mdws_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.square),
		.waddr (slot_q),
		.wdata ({smp_q[2], smp_q[1], smp_q[0]}),
		.re    (cmd.load),
		.raddr (slot_q),
		.rdata (old_raw)
	);

	// before the first wrap the replaced entry counts as zero
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			old_v[a] = full ? $signed(old_raw[a*SAMPLE_W +: SAMPLE_W]) : '0;
			pn[a]    = smp_q[a] * smp_q[a];
			po[a]    = old_v[a] * old_v[a];
			over[a]  = CMPW'(diff_s5[a]) > CMPW'(b2_s5[a]);
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
				sq_q[a]  <= '0;
			end
		end else begin
			if (cmd.square) begin
				if (slot_q == AW'(WINDOW_DEPTH - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
				for (int a = 0; a < AXES; a++) begin
					sum_q[a] <= sum_q[a] + SW'(smp_q[a]) - SW'(old_v[a]);
				end
			end
			if (cmd.accum) begin
				for (int a = 0; a < AXES; a++) begin
					sq_q[a] <= sq_q[a] + QW'(sqn_s2[a]) - QW'(sqo_s2[a]);
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		for (int a = 0; a < AXES; a++) begin
			if (cmd.load) begin
				smp_q[a] <= $signed(smp_in[a]);
			end
			if (cmd.square) begin
				sqn_s2[a] <= pn[a][PW-1:0];
				sqo_s2[a] <= po[a][PW-1:0];
			end
			if (cmd.accum) begin
				mag_s3[a] <= sum_q[a][SW-1] ? SW'(-sum_q[a]) : SW'(sum_q[a]);
			end
			if (cmd.mul1) begin
				nq_s4[a]  <= NQW'(fill_q) * NQW'(sq_q[a]);
				s2_s4[a]  <= (2*SW)'(mag_s3[a]) * (2*SW)'(mag_s3[a]);
				bnd_s4[a] <= BNW'(limits[a]) * BNW'(fill_q);
			end
			if (cmd.mul2) begin
				diff_s5[a] <= DW'(nq_s4[a]) - DW'(s2_s4[a]);
				b2_s5[a]   <= BW'(bnd_s4[a]) * BW'(bnd_s4[a]);
			end
		end
		if (cmd.cmp) begin
			moving_q <= |over;
		end
	end

	assign moving = moving_q;

endmodule

>>> rtl/core/motion_detect_window_stdev_core.sv
// ----------------------------------------------------------------------------
// motion_detect_window_stdev_core
// Motion detector: per-axis moving-window standard deviation against limits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one signed Q8.8 sample per
//   axis. Each accepted sample enters a ring of the last WINDOW_DEPTH samples
//   and yields one transfer on the output channel (out_valid / out_stall):
//   moving = 1 when any axis has n*Q - S*S > (limit*n)^2 over the window.
//   One sample is in work at a time; the sequencer steps it through ring
//   read, squaring, accumulation, two multiply stages and the compare, and
//   takes the next one only once the result is loaded. in_stall is high
//   while a sample is in work.
//   Limits are written over the APB port (limit_x/y/z at 0x0/0x4/0x8) while
//   the block is idle, a rule for the user that the block does not enforce;
//   only the low 15 bits are kept, 0xC is ignored and reads back as zero.
//   Reset clears the limits, running sums, ring fill count and write slot;
//   ring entries not yet written since reset count as zero.
//   When the receiver stalls, the result holds in the output register; the
//   next sample is still accepted and waits in its last step until free.
// ----------------------------------------------------------------------------
module motion_detect_window_stdev_core #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// samples
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] accel_x,
	input  logic [15:0] accel_y,
	input  logic [15:0] accel_z,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic        moving
);

	import mdws_pkg::*;

	limits_t  limit_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	cmd_t     cmd;
	sample_t  smp;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LIMIT_X: limit_q[0] <= pwdata[LIMIT_W-1:0];
				REG_LIMIT_Y: limit_q[1] <= pwdata[LIMIT_W-1:0];
				REG_LIMIT_Z: limit_q[2] <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LIMIT_X: prdata = 32'(limit_q[0]);
			REG_LIMIT_Y: prdata = 32'(limit_q[1]);
			REG_LIMIT_Z: prdata = 32'(limit_q[2]);
			default:     prdata = '0;
		endcase
	end

	assign smp = {accel_z, accel_y, accel_x};

	mdws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	mdws_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.smp_in (smp),
		.limits (limit_q),
		.moving (moving)
	);

endmodule
